// File: rtl/core/hpt_pkg.sv
package hpt_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FIELD_W         = 32;
  localparam int COEF_W          = 32;
  localparam int NUM_REGS        = 8;
  localparam int REG_W           = 64;
  localparam int CFG_IDX_W       = 4;
  localparam int NUM_LANES       = 4;
  localparam int FRAC_BITS       = 16;
  localparam int PIPE_STAGES     = 3;

  localparam logic CMD_AFFINE = 1'b0;
  localparam logic CMD_FULL   = 1'b1;

  localparam logic [NUM_REGS-1:0][REG_W-1:0] CFG_RESET = {
    64'd281474976710656, 64'd0, 64'd65536, 64'd0,
    64'd0, 64'd281474976710656, 64'd0, 64'd65536
  };

  typedef struct packed {
    logic                      command;
    logic signed [FIELD_W-1:0] coord_x;
    logic signed [FIELD_W-1:0] coord_y;
    logic signed [FIELD_W-1:0] coord_z;
    logic signed [FIELD_W-1:0] coord_w;
  } hpt_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic signed [FIELD_W-1:0] out_w;
    logic                      saturated;
  } hpt_out_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] val;
    logic                      clip;
  } hpt_lane_res_t;

  typedef struct packed {
    logic valid;
    logic full;
  } hpt_stage_t;

endpackage

// File: rtl/core/homogeneous_point_transform.sv
// Transforms one point per beat by a 4x4 Q16.16 matrix held in eight 64-bit
// registers, as a row vector times the matrix. Four lanes, one per output
// column, each multiply the point by a matrix column, sum the products at full
// width, shift down 16 bits and saturate; the merge stage masks w in affine
// mode and collects the saturation flag. The block accepts one beat per cycle
// unless stalled, and each beat passes through three lane pipeline stages and
// then the output register. The whole pipeline stalls only while the output
// register holds a result that has not been taken. Matrix writes take effect on
// beats accepted afterward and must be made while the pipeline is empty.
module homogeneous_point_transform import hpt_pkg::*; #(
  parameter int CoordWidth = COORD_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hpt_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hpt_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i
);

  localparam int OpW = (CoordWidth >= 18) ? CoordWidth : 18;
  localparam logic signed [OpW-1:0] QOne = OpW'(longint'(1) << FRAC_BITS);

  logic [NUM_REGS-1:0][REG_W-1:0] cfg_q;
  logic [PIPE_STAGES-1:0]         vld_q;
  logic [PIPE_STAGES-1:0]         full_q;
  logic                           adv;
  logic signed [OpW-1:0]          vec [4];
  logic signed [COEF_W-1:0]       coef [NUM_LANES][4];
  hpt_lane_res_t                  lane_res [NUM_LANES];
  hpt_stage_t                     last_stage;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && (cfg_index_i < CFG_IDX_W'(NUM_REGS))) begin
      cfg_q[cfg_index_i[$clog2(NUM_REGS)-1:0]] <= cfg_data_i;
    end
  end

  always_comb begin
    vec[0] = OpW'($signed(in_data_i.coord_x[CoordWidth-1:0]));
    vec[1] = OpW'($signed(in_data_i.coord_y[CoordWidth-1:0]));
    vec[2] = OpW'($signed(in_data_i.coord_z[CoordWidth-1:0]));
    vec[3] = (in_data_i.command == CMD_FULL) ?
             OpW'($signed(in_data_i.coord_w[CoordWidth-1:0])) : QOne;
  end

  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    for (genvar r = 0; r < 4; r++) begin : g_coef
      assign coef[c][r] = $signed(cfg_q[r * 2 + c / 2][(c % 2) * COEF_W +: COEF_W]);
    end

    hpt_lane #(
      .CoordWidth(CoordWidth)
    ) u_lane (
      .clk_i (clk_i),
      .adv_i (adv),
      .vec_i (vec),
      .coef_i(coef[c]),
      .res_o (lane_res[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      full_q <= '0;
    end else if (adv) begin
      vld_q  <= {vld_q[PIPE_STAGES-2:0], in_valid_i};
      full_q <= {full_q[PIPE_STAGES-2:0], in_data_i.command};
    end
  end

  assign last_stage.valid = vld_q[PIPE_STAGES-1];
  assign last_stage.full  = full_q[PIPE_STAGES-1];

  hpt_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stage_i    (last_stage),
    .lane_i     (lane_res),
    .adv_o      (adv),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  assign in_ready_o = adv;

`ifndef ASSERT_OFF
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted beat did not enter the first stage");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q) && $stable(full_q))
    else $error("pipeline moved while stalled");

  a_bad_index_ignored : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && (cfg_index_i >= CFG_IDX_W'(NUM_REGS)))
    |=> $stable(cfg_q))
    else $error("write beyond the register file changed the matrix");

  a_stage_feeds_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld_q[PIPE_STAGES-1]) |=> out_valid_o)
    else $error("finished beat did not reach the output register");
`endif

endmodule

// File: rtl/core/hpt_lane.sv
module hpt_lane import hpt_pkg::*; #(
  parameter int CoordWidth = COORD_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     adv_i,
  input  logic signed [CoordWidth + ((CoordWidth >= 18) ? 0 : 18 - CoordWidth) - 1:0] vec_i [4],
  input  logic signed [COEF_W-1:0] coef_i [4],
  output hpt_lane_res_t            res_o
);

  localparam int OpW  = (CoordWidth >= 18) ? CoordWidth : 18;
  localparam int PW   = OpW + COEF_W;
  localparam int SW   = PW + 2;
  localparam int TW   = SW - FRAC_BITS;
  localparam longint HiL = (longint'(1) << (CoordWidth - 1)) - 1;
  localparam longint LoL = -(longint'(1) << (CoordWidth - 1));
  localparam logic signed [TW-1:0] Hi = TW'(HiL);
  localparam logic signed [TW-1:0] Lo = TW'(LoL);

  logic signed [PW-1:0]     prod_q [4];
  logic signed [PW:0]       pair_q [2];
  logic signed [SW-1:0]     sum_q;
  logic signed [TW-1:0]     total;
  logic signed [CoordWidth-1:0] sat_val;
  logic                     clip;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 4; i++) begin
        prod_q[i] <= $signed(vec_i[i]) * $signed(coef_i[i]);
      end
      for (int j = 0; j < 2; j++) begin
        pair_q[j] <= (PW + 1)'(prod_q[2 * j]) + (PW + 1)'(prod_q[2 * j + 1]);
      end
      sum_q <= SW'(pair_q[0]) + SW'(pair_q[1]);
    end
  end

  always_comb begin
    total   = $signed(sum_q[SW-1:FRAC_BITS]);
    clip    = 1'b0;
    sat_val = CoordWidth'(total);
    if (total > Hi) begin
      clip    = 1'b1;
      sat_val = CoordWidth'(Hi);
    end else if (total < Lo) begin
      clip    = 1'b1;
      sat_val = CoordWidth'(Lo);
    end
  end

  assign res_o.val  = FIELD_W'(sat_val);
  assign res_o.clip = clip;

endmodule

// File: rtl/core/hpt_merge.sv
module hpt_merge import hpt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hpt_stage_t    stage_i,
  input  hpt_lane_res_t lane_i [NUM_LANES],
  output logic          adv_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hpt_out_t      out_data_o
);

  logic     valid_q;
  hpt_out_t data_q;
  hpt_out_t data_d;

  assign adv_o = !valid_q || out_ready_i;

  always_comb begin
    data_d.out_x     = lane_i[0].val;
    data_d.out_y     = lane_i[1].val;
    data_d.out_z     = lane_i[2].val;
    data_d.out_w     = (stage_i.full == CMD_FULL) ? lane_i[3].val : '0;
    data_d.saturated = lane_i[0].clip || lane_i[1].clip || lane_i[2].clip ||
                       ((stage_i.full == CMD_FULL) && lane_i[3].clip);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && stage_i.valid) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// File: sim/hpt_checker.sv
`timescale 1ns / 1ps

module hpt_checker import hpt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  hpt_in_t              in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  hpt_out_t             out_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef logic [NUM_REGS-1:0][REG_W-1:0] hpt_mat_t;

  hpt_mat_t matrix_q;
  hpt_out_t expected_points[$];
  int       mismatches;
  int       waiting;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  function automatic hpt_out_t transform_point(input hpt_in_t pt, input hpt_mat_t mat);
    logic signed [FIELD_W-1:0] vec [NUM_LANES];
    logic signed [FIELD_W-1:0] lane [NUM_LANES];
    logic                      lane_clip [NUM_LANES];
    logic signed [79:0]        acc;
    logic signed [79:0]        a;
    logic signed [79:0]        b;
    logic signed [79:0]        sh;
    logic [REG_W-1:0]          word;
    logic signed [COEF_W-1:0]  cf;
    hpt_out_t                  res;
    vec[0] = pt.coord_x;
    vec[1] = pt.coord_y;
    vec[2] = pt.coord_z;
    vec[3] = (pt.command == CMD_FULL) ? pt.coord_w : (32'sd1 <<< FRAC_BITS);
    for (int col = 0; col < NUM_LANES; col++) begin
      acc = '0;
      for (int row = 0; row < NUM_LANES; row++) begin
        word = mat[row * 2 + col / 2];
        cf   = col[0] ? word[63:32] : word[31:0];
        a    = vec[row];
        b    = cf;
        acc  = acc + a * b;
      end
      sh = acc >>> FRAC_BITS;
      if ((sh[79:31] == '0) || (sh[79:31] == '1)) begin
        lane[col]      = sh[31:0];
        lane_clip[col] = 1'b0;
      end else begin
        lane[col]      = sh[79] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        lane_clip[col] = 1'b1;
      end
    end
    res.out_x     = lane[0];
    res.out_y     = lane[1];
    res.out_z     = lane[2];
    res.saturated = lane_clip[0] | lane_clip[1] | lane_clip[2];
    if (pt.command == CMD_FULL) begin
      res.out_w     = lane[3];
      res.saturated = res.saturated | lane_clip[3];
    end else begin
      res.out_w = '0;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, $signed(exp_v), $signed(act_v));
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hpt_out_t exp_pt;
    if (!rst_ni) begin
      matrix_q = CFG_RESET;
      expected_points.delete();
      mismatches = 0;
      waiting = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_points.size() == 0) begin
          $error("result beat with no expected point: x %0d y %0d z %0d w %0d sat %0b",
                 out_data_i.out_x, out_data_i.out_y, out_data_i.out_z,
                 out_data_i.out_w, out_data_i.saturated);
          mismatches++;
        end else begin
          exp_pt = expected_points.pop_front();
          check_field("out_x", exp_pt.out_x, out_data_i.out_x);
          check_field("out_y", exp_pt.out_y, out_data_i.out_y);
          check_field("out_z", exp_pt.out_z, out_data_i.out_z);
          check_field("out_w", exp_pt.out_w, out_data_i.out_w);
          check_field("saturated", {31'd0, exp_pt.saturated}, {31'd0, out_data_i.saturated});
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_points.push_back(transform_point(in_data_i, matrix_q));
      end
      if (cfg_valid_i && cfg_ready_i && (cfg_index_i < NUM_REGS)) begin
        matrix_q[cfg_index_i[$clog2(NUM_REGS)-1:0]] = cfg_data_i;
      end
      waiting = expected_points.size();
    end
  end

endmodule

// File: sim/tb_homogeneous_point_transform.sv
`timescale 1ns / 1ps

module tb_homogeneous_point_transform;
  import hpt_pkg::*;

  localparam int CycleLimit = 300000;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] hpt_mat_t;
  typedef enum int {MAT_RANDOM, MAT_NARROW, MAT_EXTREME, MAT_RESET} mat_kind_e;
  typedef enum int {PT_RANDOM, PT_NARROW, PT_EXTREME} pt_kind_e;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  hpt_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  hpt_out_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending;
  int                   idle_pct;
  int                   stall_pct;
  int                   cycle_count;

  homogeneous_point_transform u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  hpt_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic hpt_in_t make_point(input logic cmd, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] z,
                                         input logic [31:0] w);
    hpt_in_t pt;
    pt.command = cmd;
    pt.coord_x = x;
    pt.coord_y = y;
    pt.coord_z = z;
    pt.coord_w = w;
    return pt;
  endfunction

  function automatic logic [31:0] extreme_value();
    case ($urandom_range(0, 6))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0000_0001;
      5:       return 32'h0001_0000;
      default: return 32'hFFFF_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord(input pt_kind_e kind);
    case (kind)
      PT_NARROW:  return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      PT_EXTREME: return extreme_value();
      default:    return $urandom;
    endcase
  endfunction

  function automatic hpt_in_t rand_point();
    pt_kind_e kind;
    kind = pt_kind_e'($urandom_range(0, 2));
    return make_point($urandom_range(0, 1) ? CMD_FULL : CMD_AFFINE, rand_coord(kind),
                      rand_coord(kind), rand_coord(kind), rand_coord(kind));
  endfunction

  function automatic logic [31:0] rand_coef(input mat_kind_e kind);
    case (kind)
      MAT_NARROW:  return $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
      MAT_EXTREME: return extreme_value();
      default:     return $urandom;
    endcase
  endfunction

  function automatic hpt_mat_t rand_matrix(input mat_kind_e kind);
    hpt_mat_t m;
    if (kind == MAT_RESET) begin
      m = CFG_RESET;
    end else begin
      for (int r = 0; r < NUM_REGS; r++) begin
        m[r] = {rand_coef(kind), rand_coef(kind)};
      end
    end
    return m;
  endfunction

  function automatic hpt_mat_t fill_matrix(input logic [REG_W-1:0] cols01,
                                           input logic [REG_W-1:0] cols23);
    hpt_mat_t m;
    for (int r = 0; r < NUM_REGS; r++) begin
      m[r] = r[0] ? cols23 : cols01;
    end
    return m;
  endfunction

  task automatic send_point(input hpt_in_t pt);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = pt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // The pipeline must be empty before the matrix changes, so the sender
  // holds off until every outstanding point has come back.
  task automatic load_matrix(input hpt_mat_t m);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    for (int i = 0; i <= NUM_REGS; i++) begin
      cfg_valid = 1'b1;
      if (i == NUM_REGS) begin
        cfg_index = CFG_IDX_W'($urandom_range(NUM_REGS, 2 ** CFG_IDX_W - 1));
        cfg_data  = {$urandom, $urandom};
      end else begin
        cfg_index = CFG_IDX_W'(i);
        cfg_data  = m[i];
      end
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_pct  = 0;
    stall_pct = 0;
    rst_n     = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    send_point(make_point(CMD_AFFINE, 0, 0, 0, 32'h7FFF_FFFF));
    send_point(make_point(CMD_FULL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_point(make_point(CMD_FULL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_point(make_point(CMD_AFFINE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0));
    send_point(make_point(CMD_FULL, 1, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000));
    send_point(make_point(CMD_AFFINE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));

    load_matrix(fill_matrix({2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}}));
    send_point(make_point(CMD_FULL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_point(make_point(CMD_FULL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_point(make_point(CMD_AFFINE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    send_point(make_point(CMD_FULL, 1, 0, 0, 0));
    send_point(make_point(CMD_FULL, 32'hFFFF_FFFF, 0, 0, 0));

    load_matrix(fill_matrix({2{32'h8000_0000}}, {2{32'h8000_0000}}));
    send_point(make_point(CMD_FULL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_point(make_point(CMD_AFFINE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
    send_point(make_point(CMD_FULL, 0, 0, 0, 0));
    send_point(make_point(CMD_FULL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));

    // Only the w column is nonzero, so clipping shows up in full mode alone.
    load_matrix(fill_matrix(64'd0, {32'h7FFF_FFFF, 32'h0000_0000}));
    send_point(make_point(CMD_AFFINE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    send_point(make_point(CMD_FULL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));

    load_matrix(fill_matrix(64'd0, 64'd0));
    send_point(make_point(CMD_FULL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      for (int ld = 0; ld < 4; ld++) begin
        load_matrix(rand_matrix(mat_kind_e'($urandom_range(0, 3))));
        for (int k = 0; k < 100; k++) begin
          send_point(rand_point());
        end
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2 * PIPE_STAGES + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: homogeneous_point_transform.f
rtl/core/hpt_pkg.sv
rtl/core/hpt_lane.sv
rtl/core/hpt_merge.sv
rtl/core/homogeneous_point_transform.sv
sim/hpt_checker.sv
sim/tb_homogeneous_point_transform.sv
